FILE: hdl/ndls_pkg.sv
// Shared types and constants of the damped Newton line-search controller.
package ndls_pkg;

	localparam int MODE_WIDTH      = 2;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CNT_WIDTH       = 16;
	localparam int REC_CNT_WIDTH   = 5;
	localparam int TENTH_DIVISOR   = 10;
	localparam int RES_TARGET_INIT = 16777;
	localparam int MAX_OUTER_INIT  = 100;

	typedef enum logic [MODE_WIDTH-1:0] {
		MODE_OUTER = 2'd0,
		MODE_INNER = 2'd1,
		MODE_TRIAL = 2'd2,
		MODE_INIT  = 2'd3
	} mode_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_INIT_OUTER  = 3'd0,
		CFG_INIT_DAMP   = 3'd1,
		CFG_MIN_DAMP    = 3'd2,
		CFG_MAX_REC     = 3'd3,
		CFG_RAISE_STEPS = 3'd4,
		CFG_RES_TARGET  = 3'd5,
		CFG_MAX_OUTER   = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SEL_SQ1  = 3'd0,
		SEL_SQ2  = 3'd1,
		SEL_BSQ1 = 3'd2,
		SEL_ASQ2 = 3'd3,
		SEL_AD2  = 3'd4,
		SEL_BD1  = 3'd5,
		SEL_QD1  = 3'd6,
		SEL_DIV  = 3'd7
	} sel_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_EVENT    = 3'd1,
		ST_MUL_GO   = 3'd2,
		ST_MUL_WAIT = 3'd3,
		ST_SIGNS    = 3'd4,
		ST_CHECK    = 3'd5,
		ST_DIV_WAIT = 3'd6,
		ST_RESULT   = 3'd7
	} state_t;

	typedef struct packed {
		logic ev;
		logic go;
		logic div_tenth;
		sel_t sel;
		logic mul_store;
		logic div_store;
		logic ls_halve;
	} cmd_t;

	typedef struct packed {
		logic need_ls;
		logic ls_ok;
		logic cmp_low;
		logic cmp_high;
		logic mdu_done;
	} status_t;

endpackage

FILE: hdl/ndls_ifs.sv
// Request, result and configuration channel interfaces.
interface ndls_in_if #(parameter int RES_WIDTH = 48) ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           mode;
	logic [RES_WIDTH-1:0] user_residual;
	logic [RES_WIDTH-1:0] normalized_residual_in;
	modport source (output valid, mode, user_residual, normalized_residual_in, input ready);
	modport sink (input valid, mode, user_residual, normalized_residual_in, output ready);
endinterface

interface ndls_out_if #(parameter int RES_WIDTH = 48, parameter int DAMP_WIDTH = 32) ();
	logic                  valid;
	logic                  ready;
	logic                  proceed;
	logic [DAMP_WIDTH-1:0] damping_out;
	logic                  converged;
	logic                  limit_reached;
	logic                  recovery_active;
	logic [RES_WIDTH-1:0]  outer_residual;
	modport source (output valid, proceed, damping_out, converged, limit_reached,
		recovery_active, outer_residual, input ready);
	modport sink (input valid, proceed, damping_out, converged, limit_reached,
		recovery_active, outer_residual, output ready);
endinterface

interface ndls_cfg_if #(parameter int DATA_WIDTH = 48) ();
	logic                  valid;
	logic                  ready;
	logic [2:0]            index;
	logic [DATA_WIDTH-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/ndls_mdu.sv
// Shared shift-and-add multiplier and restoring divider for the line search.
module ndls_mdu #(
	parameter int WIDTH      = 116,
	parameter int DAMP_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             is_div,
	input  logic [WIDTH-1:0] op_a,
	input  logic [WIDTH-1:0] op_b,
	output logic             done,
	output logic [WIDTH-1:0] res
);
	localparam int CW = $clog2(DAMP_WIDTH);

	logic             busy_q, div_q, done_q;
	logic [WIDTH-1:0] acc_q, ma_q, mb_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				div_q  <= is_div;
			end else if (busy_q) begin
				if (div_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else if (mb_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (is_div) begin
				acc_q <= op_a;
				ma_q  <= op_b << (DAMP_WIDTH - 1);
				mb_q  <= '0;
				cnt_q <= CW'(DAMP_WIDTH - 1);
			end else begin
				acc_q <= '0;
				ma_q  <= op_a;
				mb_q  <= op_b;
			end
		end else if (busy_q) begin
			if (div_q) begin
				if (acc_q >= ma_q) begin
					acc_q <= acc_q - ma_q;
					mb_q  <= {mb_q[WIDTH-2:0], 1'b1};
				end else begin
					mb_q <= {mb_q[WIDTH-2:0], 1'b0};
				end
				ma_q  <= ma_q >> 1;
				cnt_q <= cnt_q - CW'(1);
			end else if (mb_q != '0) begin
				if (mb_q[0]) begin
					acc_q <= acc_q + ma_q;
				end
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign res  = div_q ? mb_q : acc_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n) go |-> !busy_q)
		else $error("operation started while unit busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("done held longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("done raised while busy");

endmodule

FILE: hdl/ndls_dp.sv
// Datapath: configuration, solver state, line-search operands and results.
module ndls_dp #(
	parameter int RES_WIDTH  = 48,
	parameter int DAMP_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [((RES_WIDTH > DAMP_WIDTH) ? RES_WIDTH : DAMP_WIDTH)-1:0] cfg_data,
	input  logic [1:0]                   mode,
	input  logic [RES_WIDTH-1:0]         user_residual,
	input  logic [RES_WIDTH-1:0]         normalized_residual_in,
	input  ndls_pkg::cmd_t               cmd,
	output ndls_pkg::status_t            status,
	output logic                         proceed,
	output logic [DAMP_WIDTH-1:0]        damping_out,
	output logic                         converged,
	output logic                         limit_reached,
	output logic                         recovery_active,
	output logic [RES_WIDTH-1:0]         outer_residual
);
	import ndls_pkg::*;

	localparam int W   = RES_WIDTH + 2 * DAMP_WIDTH + 4;
	localparam int DW  = DAMP_WIDTH;
	localparam int RW  = RES_WIDTH;
	localparam logic [DW-1:0] DAMP_TWO = DW'(1) << (DW - 1);
	localparam logic [DW+4:0] TENTH_SCALE = (DW+5)'(1) << (DW + 4);
	localparam logic [DW:0]   TENTH_RECIP = (DW+1)'((TENTH_SCALE
		+ (DW+5)'(TENTH_DIVISOR - 1)) / (DW+5)'(TENTH_DIVISOR));

	logic [CNT_WIDTH-1:0]     init_outer_q, max_outer_q;
	logic [DW-1:0]            init_damp_q, min_damp_q, max_rec_q;
	logic [REC_CNT_WIDTH-1:0] raise_q;
	logic [RW-1:0]            target_q;

	logic [RW-1:0]            outer_res_q, trial_res_q, prev_trial_q, norm_res_q;
	logic [DW-1:0]            damp_q, prev_damp_q;
	logic [CNT_WIDTH-1:0]     outer_cnt_q, inner_cnt_q;
	logic [REC_CNT_WIDTH-1:0] rec_cnt_q;
	logic                     init_flag_q, rec_flag_q;
	logic                     proceed_q, conv_q, lim_q, need_ls_q;

	logic [DW-1:0]            d1_q, d2_q;
	logic [RW-1:0]            am_q, bm_q;
	logic                     an_q, bn_q;
	logic [2*DW-1:0]          sq1_q, sq2_q;
	logic [W-1:0]             n1_q, n2_q, qd_q;
	logic                     tenth_q;

	mode_t                    ev_mode;
	logic [CNT_WIDTH-1:0]     oc_inc, ic_inc;
	logic [REC_CNT_WIDTH-1:0] rc_inc, shamt;
	logic                     conv, lim, done;
	logic [DW-1:0]            rec_val, cand, cand_fin;
	logic                     rec_hit;
	logic [W-1:0]             mdu_res, sprod_a, sprod_b, p_mag, q_mag, p5;
	logic [W-1:0]             op_a, op_b;
	logic                     n1_neg, n2_neg, mdu_done;

	assign ev_mode = mode_t'(mode);
	assign oc_inc  = (outer_cnt_q == '1) ? outer_cnt_q : outer_cnt_q + CNT_WIDTH'(1);
	assign ic_inc  = (inner_cnt_q == '1) ? inner_cnt_q : inner_cnt_q + CNT_WIDTH'(1);
	assign rc_inc  = (rec_cnt_q == '1) ? rec_cnt_q : rec_cnt_q + REC_CNT_WIDTH'(1);
	assign conv    = target_q > norm_res_q;
	assign lim     = oc_inc > max_outer_q;
	assign done    = trial_res_q < outer_res_q;

	assign shamt   = raise_q - rec_cnt_q;
	assign rec_val = (rec_cnt_q < raise_q) ? (max_rec_q >> shamt) : max_rec_q;

	always_comb begin
		cand = d1_q >> 1;
		if (cmd.div_store) begin
			cand = tenth_q ? mdu_res[DW+4 +: DW] : mdu_res[DW-1:0];
		end else if (cmd.ev) begin
			cand = damp_q >> 1;
		end
	end
	assign rec_hit  = cand < min_damp_q;
	assign cand_fin = rec_hit ? rec_val : cand;

	assign n1_neg  = n1_q[W-1];
	assign n2_neg  = n2_q[W-1];
	assign p_mag   = n1_neg ? (~n1_q + W'(1)) : n1_q;
	assign q_mag   = n2_neg ? (~n2_q + W'(1)) : n2_q;
	assign p5      = (p_mag << 2) + p_mag;
	assign sprod_a = an_q ? (~mdu_res + W'(1)) : mdu_res;
	assign sprod_b = bn_q ? (~mdu_res + W'(1)) : mdu_res;

	always_comb begin
		case (cmd.sel)
			SEL_SQ1: begin
				op_a = W'(d1_q);
				op_b = W'(d1_q);
			end
			SEL_SQ2: begin
				op_a = W'(d2_q);
				op_b = W'(d2_q);
			end
			SEL_BSQ1: begin
				op_a = W'(sq1_q);
				op_b = W'(bm_q);
			end
			SEL_ASQ2: begin
				op_a = W'(sq2_q);
				op_b = W'(am_q);
			end
			SEL_AD2: begin
				op_a = W'(am_q);
				op_b = W'(d2_q);
			end
			SEL_BD1: begin
				op_a = W'(bm_q);
				op_b = W'(d1_q);
			end
			SEL_QD1: begin
				op_a = q_mag;
				op_b = W'(d1_q);
			end
			default: begin
				op_a = cmd.div_tenth ? W'(TENTH_RECIP) : p_mag;
				op_b = cmd.div_tenth ? W'(d1_q) : (q_mag << 1);
			end
		endcase
	end

	ndls_mdu #(.WIDTH(W), .DAMP_WIDTH(DW)) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.go),
		.is_div ((cmd.sel == SEL_DIV) && !cmd.div_tenth),
		.op_a   (op_a),
		.op_b   (op_b),
		.done   (mdu_done),
		.res    (mdu_res)
	);

	always_comb begin
		status.need_ls  = need_ls_q;
		status.ls_ok    = (n1_q != '0) && (n2_q != '0) && (n2_neg != (d1_q > d2_q))
			&& (n1_neg == (d1_q > d2_q));
		status.cmp_low  = p5 < qd_q;
		status.cmp_high = p_mag > qd_q;
		status.mdu_done = mdu_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_outer_q <= '0;
			init_damp_q  <= DW'(1) << (DW - 2);
			min_damp_q   <= DW'(1) << (DW - 12);
			max_rec_q    <= DW'(1) << (DW - 2);
			raise_q      <= '0;
			target_q     <= RW'(RES_TARGET_INIT);
			max_outer_q  <= CNT_WIDTH'(MAX_OUTER_INIT);
			outer_res_q  <= '1;
			trial_res_q  <= '1;
			prev_trial_q <= '1;
			norm_res_q   <= '1;
			damp_q       <= DAMP_TWO;
			prev_damp_q  <= DAMP_TWO;
			outer_cnt_q  <= '0;
			inner_cnt_q  <= '0;
			rec_cnt_q    <= '0;
			init_flag_q  <= 1'b0;
			rec_flag_q   <= 1'b0;
			proceed_q    <= 1'b0;
			conv_q       <= 1'b0;
			lim_q        <= 1'b0;
			need_ls_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_INIT_OUTER:  init_outer_q <= cfg_data[CNT_WIDTH-1:0];
					CFG_INIT_DAMP:   init_damp_q  <= cfg_data[DW-1:0];
					CFG_MIN_DAMP:    min_damp_q   <= cfg_data[DW-1:0];
					CFG_MAX_REC:     max_rec_q    <= cfg_data[DW-1:0];
					CFG_RAISE_STEPS: raise_q      <= cfg_data[REC_CNT_WIDTH-1:0];
					CFG_RES_TARGET:  target_q     <= cfg_data[RW-1:0];
					CFG_MAX_OUTER:   max_outer_q  <= cfg_data[CNT_WIDTH-1:0];
					default: ;
				endcase
			end
			if (cmd.ev) begin
				proceed_q <= 1'b0;
				conv_q    <= 1'b0;
				lim_q     <= 1'b0;
				need_ls_q <= 1'b0;
				unique case (ev_mode)
					MODE_OUTER: begin
						conv_q    <= conv;
						lim_q     <= lim;
						proceed_q <= !conv && !lim;
						if (conv || lim) begin
							outer_cnt_q <= '0;
							outer_res_q <= '1;
							trial_res_q <= '1;
							norm_res_q  <= '1;
						end else begin
							outer_cnt_q <= oc_inc;
						end
					end
					MODE_INNER: begin
						if (done || rec_flag_q || init_flag_q) begin
							inner_cnt_q <= '0;
							damp_q      <= DAMP_TWO;
							init_flag_q <= 1'b0;
							outer_res_q <= trial_res_q;
							if (rec_flag_q) begin
								rec_flag_q <= 1'b0;
								rec_cnt_q  <= rc_inc;
							end else begin
								rec_cnt_q <= '0;
							end
						end else begin
							proceed_q   <= 1'b1;
							inner_cnt_q <= ic_inc;
							if (outer_cnt_q <= init_outer_q) begin
								damp_q      <= init_damp_q;
								init_flag_q <= 1'b1;
							end else begin
								prev_damp_q <= damp_q;
								if (ic_inc <= CNT_WIDTH'(2) || damp_q == '0
									|| prev_damp_q == '0 || damp_q == prev_damp_q) begin
									damp_q     <= cand_fin;
									rec_flag_q <= rec_hit;
								end else begin
									need_ls_q <= 1'b1;
								end
							end
						end
					end
					MODE_TRIAL: begin
						prev_trial_q <= trial_res_q;
						trial_res_q  <= user_residual;
					end
					MODE_INIT: begin
						norm_res_q <= normalized_residual_in;
						if (outer_cnt_q == CNT_WIDTH'(1)) begin
							outer_res_q <= user_residual;
						end
					end
					default: ;
				endcase
			end else if (cmd.ls_halve || cmd.div_store) begin
				damp_q     <= cand_fin;
				rec_flag_q <= rec_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ev) begin
			d1_q <= damp_q;
			d2_q <= prev_damp_q;
			an_q <= trial_res_q < outer_res_q;
			am_q <= (trial_res_q >= outer_res_q) ? trial_res_q - outer_res_q
				: outer_res_q - trial_res_q;
			bn_q <= prev_trial_q < outer_res_q;
			bm_q <= (prev_trial_q >= outer_res_q) ? prev_trial_q - outer_res_q
				: outer_res_q - prev_trial_q;
		end
		if (cmd.go) begin
			tenth_q <= cmd.div_tenth;
		end
		if (cmd.mul_store) begin
			case (cmd.sel)
				SEL_SQ1:  sq1_q <= mdu_res[2*DW-1:0];
				SEL_SQ2:  sq2_q <= mdu_res[2*DW-1:0];
				SEL_BSQ1: n1_q  <= sprod_b;
				SEL_ASQ2: n1_q  <= n1_q - sprod_a;
				SEL_AD2:  n2_q  <= sprod_a;
				SEL_BD1:  n2_q  <= n2_q - sprod_b;
				SEL_QD1:  qd_q  <= mdu_res;
				default: ;
			endcase
		end
	end

	assign proceed         = proceed_q;
	assign damping_out     = damp_q;
	assign converged       = conv_q;
	assign limit_reached   = lim_q;
	assign recovery_active = rec_flag_q;
	assign outer_residual  = outer_res_q;

endmodule

FILE: hdl/ndls_ctrl.sv
// Controller: request handshake and sequencing of the line-search steps.
module ndls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ndls_pkg::status_t status,
	output ndls_pkg::cmd_t    cmd
);
	import ndls_pkg::*;

	state_t st_q, st_n;
	sel_t   step_q, step_n, step_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			step_q <= SEL_SQ1;
		end else begin
			st_q   <= st_n;
			step_q <= step_n;
		end
	end

	always_comb begin
		unique case (step_q)
			SEL_SQ1:  step_next = SEL_SQ2;
			SEL_SQ2:  step_next = SEL_BSQ1;
			SEL_BSQ1: step_next = SEL_ASQ2;
			SEL_ASQ2: step_next = SEL_AD2;
			SEL_AD2:  step_next = SEL_BD1;
			default:  step_next = SEL_QD1;
		endcase
	end

	always_comb begin
		st_n      = st_q;
		step_n    = step_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.sel   = step_q;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ev = 1'b1;
					st_n   = ST_EVENT;
				end
			end
			ST_EVENT: begin
				if (status.need_ls) begin
					step_n = SEL_SQ1;
					st_n   = ST_MUL_GO;
				end else begin
					st_n = ST_RESULT;
				end
			end
			ST_MUL_GO: begin
				cmd.go = 1'b1;
				st_n   = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (status.mdu_done) begin
					cmd.mul_store = 1'b1;
					if (step_q == SEL_BD1) begin
						st_n = ST_SIGNS;
					end else if (step_q == SEL_QD1) begin
						st_n = ST_CHECK;
					end else begin
						step_n = step_next;
						st_n   = ST_MUL_GO;
					end
				end
			end
			ST_SIGNS: begin
				if (status.ls_ok) begin
					step_n = SEL_QD1;
					st_n   = ST_MUL_GO;
				end else begin
					cmd.ls_halve = 1'b1;
					st_n         = ST_RESULT;
				end
			end
			ST_CHECK: begin
				if (status.cmp_low || !status.cmp_high) begin
					cmd.go        = 1'b1;
					cmd.sel       = SEL_DIV;
					cmd.div_tenth = status.cmp_low;
					st_n          = ST_DIV_WAIT;
				end else begin
					cmd.ls_halve = 1'b1;
					st_n         = ST_RESULT;
				end
			end
			ST_DIV_WAIT: begin
				cmd.sel = SEL_DIV;
				if (status.mdu_done) begin
					cmd.div_store = 1'b1;
					st_n          = ST_RESULT;
				end
			end
			ST_RESULT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					st_n = ST_IDLE;
				end
			end
			default: st_n = ST_IDLE;
		endcase
	end

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.mdu_done |-> (st_q == ST_MUL_WAIT || st_q == ST_DIV_WAIT))
		else $error("unit finished outside a wait state");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before it was taken");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("request taken while a result is pending");

endmodule

FILE: hdl/newton_damping_line_search_control.sv
// Top level of the damped Newton line-search controller.
// Outer check, trial and initial update: states ST_IDLE, ST_EVENT, then ST_RESULT.
// Inner check with quadratic search: its multiplies and divide run in turn on the shared
// one-bit-per-cycle multiply/divide unit.
// One request at a time; the next is taken once the result has been delivered.
// Asynchronous active-low reset clears state: damping 2.0, residuals all ones.
module newton_damping_line_search_control #(
	parameter int RES_WIDTH  = 48,
	parameter int DAMP_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	ndls_in_if.sink     item,
	ndls_out_if.source  result,
	ndls_cfg_if.sink    cfg
);
	import ndls_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	ndls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	ndls_dp #(.RES_WIDTH(RES_WIDTH), .DAMP_WIDTH(DAMP_WIDTH)) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg.valid),
		.cfg_index              (cfg.index),
		.cfg_data               (cfg.data),
		.mode                   (item.mode),
		.user_residual          (item.user_residual),
		.normalized_residual_in (item.normalized_residual_in),
		.cmd                    (cmd),
		.status                 (status),
		.proceed                (result.proceed),
		.damping_out            (result.damping_out),
		.converged              (result.converged),
		.limit_reached          (result.limit_reached),
		.recovery_active        (result.recovery_active),
		.outer_residual         (result.outer_residual)
	);

endmodule

FILE: tb/tb_newton_damping_line_search_control.sv
// Self-checking testbench of the damped Newton line-search controller: driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_newton_damping_line_search_control;
	import ndls_pkg::*;

	localparam int RW = 48;
	localparam int DW = 32;
	localparam logic [RW-1:0] RES_ONES = {RW{1'b1}};
	localparam logic [DW-1:0] DAMP_TWO = {1'b1, {(DW-1){1'b0}}};

	typedef struct {
		bit             is_cfg;
		bit             hold;
		int             gap;
		mode_t          mode;
		logic [RW-1:0]  ures;
		logic [RW-1:0]  nres;
		cfg_idx_t       idx;
		logic [RW-1:0]  data;
	} request_t;

	typedef struct packed {
		logic          proceed;
		logic [DW-1:0] damping;
		logic          conv;
		logic          lim;
		logic          rec;
		logic [RW-1:0] ores;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ndls_in_if  #(.RES_WIDTH(RW)) item_ch ();
	ndls_out_if #(.RES_WIDTH(RW), .DAMP_WIDTH(DW)) res_ch ();
	ndls_cfg_if #(.DATA_WIDTH(RW)) cfg_ch ();

	newton_damping_line_search_control #(.RES_WIDTH(RW), .DAMP_WIDTH(DW)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// controller settings and state as predicted
	logic [15:0]   c_init_outer, c_max_outer;
	logic [DW-1:0] c_init_damp, c_min_damp, c_max_rec;
	logic [4:0]    c_raise;
	logic [RW-1:0] c_target;

	logic [RW-1:0] s_outer, s_trial, s_prev_trial, s_norm;
	logic [DW-1:0] s_damp, s_prev_damp;
	int            s_outer_cnt, s_inner_cnt, s_rec_cnt;
	bit            s_init, s_rec;

	request_t pending[$];
	verdict_t expected_results[$];
	int       sent_cnt = 0;
	int       got_cnt = 0;
	int       errors = 0;
	bit       out_calm = 1'b0;
	bit       in_calm = 1'b0;
	int       gap_cnt = 0;
	int       stall_cnt = 0;

	function automatic logic [RW-1:0] rand_res();
		logic [RW-1:0] v;
		v = RW'({$urandom(), $urandom()});
		return v;
	endfunction

	task automatic apply_setting(cfg_idx_t idx, logic [RW-1:0] v);
		case (idx)
			CFG_INIT_OUTER:  c_init_outer = v[15:0];
			CFG_INIT_DAMP:   c_init_damp = v[DW-1:0];
			CFG_MIN_DAMP:    c_min_damp = v[DW-1:0];
			CFG_MAX_REC:     c_max_rec = v[DW-1:0];
			CFG_RAISE_STEPS: c_raise = v[4:0];
			CFG_RES_TARGET:  c_target = v;
			CFG_MAX_OUTER:   c_max_outer = v[15:0];
			default: ;
		endcase
	endtask

	function automatic void search_damping();
		logic [DW-1:0]      d1, d2;
		logic signed [255:0] a, b, n1, n2;
		logic [255:0]       p, q, qd;
		bit                 dneg;
		d1 = s_damp;
		d2 = s_prev_damp;
		s_prev_damp = d1;
		if (d1 == 0 || d2 == 0 || d1 == d2) begin
			s_damp = d1 >> 1;
			return;
		end
		dneg = d1 < d2;
		a = $signed({208'd0, s_trial}) - $signed({208'd0, s_outer});
		b = $signed({208'd0, s_prev_trial}) - $signed({208'd0, s_outer});
		n1 = b * $signed({224'd0, d1}) * $signed({224'd0, d1})
			- a * $signed({224'd0, d2}) * $signed({224'd0, d2});
		n2 = a * $signed({224'd0, d2}) - b * $signed({224'd0, d1});
		if (n1 == 0 || n2 == 0 || ((n2 < 0) != dneg) || ((n1 < 0) == dneg)) begin
			s_damp = d1 >> 1;
			return;
		end
		p = (n1 < 0) ? -n1 : n1;
		q = (n2 < 0) ? -n2 : n2;
		qd = q * {224'd0, d1};
		if (p * 256'd5 < qd)
			s_damp = d1 / 10;
		else if (p > qd)
			s_damp = d1 >> 1;
		else
			s_damp = DW'(p / (q << 1));
	endfunction

	function automatic bit inner_step();
		bit            done;
		logic [DW-1:0] r;
		done = s_trial < s_outer;
		if (s_inner_cnt < 65535) s_inner_cnt++;
		if (done || s_rec || s_init) begin
			s_inner_cnt = 0;
			s_damp = DAMP_TWO;
			s_init = 1'b0;
			s_outer = s_trial;
			if (s_rec) begin
				s_rec = 1'b0;
				if (s_rec_cnt < 31) s_rec_cnt++;
			end else begin
				s_rec_cnt = 0;
			end
			return 1'b0;
		end
		if (s_outer_cnt <= c_init_outer) begin
			s_damp = c_init_damp;
			s_init = 1'b1;
		end else begin
			if (s_inner_cnt <= 2) begin
				s_prev_damp = s_damp;
				s_damp = s_damp >> 1;
			end else begin
				search_damping();
			end
			if (s_damp < c_min_damp) begin
				r = c_max_rec;
				if (s_rec_cnt < c_raise) r = r >> (c_raise - s_rec_cnt);
				s_damp = r;
				s_rec = 1'b1;
			end
		end
		return 1'b1;
	endfunction

	function automatic verdict_t predict_event(mode_t m, logic [RW-1:0] u, logic [RW-1:0] n);
		verdict_t v;
		v = '0;
		case (m)
			MODE_OUTER: begin
				if (s_outer_cnt < 65535) s_outer_cnt++;
				v.conv = c_target > s_norm;
				v.lim = s_outer_cnt > c_max_outer;
				if (v.conv || v.lim) begin
					s_outer_cnt = 0;
					s_outer = RES_ONES;
					s_trial = RES_ONES;
					s_norm = RES_ONES;
				end
				v.proceed = !v.conv && !v.lim;
			end
			MODE_INNER: v.proceed = inner_step();
			MODE_TRIAL: begin
				s_prev_trial = s_trial;
				s_trial = u;
			end
			default: begin
				s_norm = n;
				if (s_outer_cnt == 1) s_outer = u;
			end
		endcase
		v.damping = s_damp;
		v.rec = s_rec;
		v.ores = s_outer;
		return v;
	endfunction

	// driver
	always @(posedge clk) begin
		bit       take_item, take_cfg, nv_item, nv_cfg, idle;
		request_t head;
		if (arst_n) begin
			take_item = item_ch.valid && item_ch.ready;
			take_cfg = cfg_ch.valid && cfg_ch.ready;
			nv_item = item_ch.valid && !take_item;
			nv_cfg = cfg_ch.valid && !take_cfg;
			if (take_item) begin
				expected_results.push_back(predict_event(mode_t'(item_ch.mode),
					item_ch.user_residual, item_ch.normalized_residual_in));
				sent_cnt <= sent_cnt + 1;
			end
			if (take_cfg)
				apply_setting(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
			idle = !take_item && !item_ch.valid && sent_cnt == got_cnt;
			if (!nv_item && !nv_cfg && pending.size() > 0) begin
				head = pending[0];
				if (gap_cnt < head.gap) begin
					gap_cnt <= gap_cnt + 1;
				end else if (!(head.is_cfg || head.hold) || idle) begin
					gap_cnt <= 0;
					void'(pending.pop_front());
					if (head.is_cfg) begin
						nv_cfg = 1'b1;
						cfg_ch.index <= head.idx;
						cfg_ch.data <= head.data;
					end else begin
						nv_item = 1'b1;
						item_ch.mode <= head.mode;
						item_ch.user_residual <= head.ures;
						item_ch.normalized_residual_in <= head.nres;
					end
				end
			end
			item_ch.valid <= nv_item;
			cfg_ch.valid <= nv_cfg;
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t want;
		int       stall;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got_cnt <= got_cnt + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing outstanding", $time);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (res_ch.proceed !== want.proceed) begin
						$display("%0t: proceed exp %0d got %0d", $time, want.proceed, res_ch.proceed);
						errors++;
					end
					if (res_ch.damping_out !== want.damping) begin
						$display("%0t: damping_out exp %h got %h", $time, want.damping,
							res_ch.damping_out);
						errors++;
					end
					if (res_ch.converged !== want.conv) begin
						$display("%0t: converged exp %0d got %0d", $time, want.conv,
							res_ch.converged);
						errors++;
					end
					if (res_ch.limit_reached !== want.lim) begin
						$display("%0t: limit_reached exp %0d got %0d", $time, want.lim,
							res_ch.limit_reached);
						errors++;
					end
					if (res_ch.recovery_active !== want.rec) begin
						$display("%0t: recovery_active exp %0d got %0d", $time, want.rec,
							res_ch.recovery_active);
						errors++;
					end
					if (res_ch.outer_residual !== want.ores) begin
						$display("%0t: outer_residual exp %h got %h", $time, want.ores,
							res_ch.outer_residual);
						errors++;
					end
				end
				stall = out_calm ? 0 : $urandom_range(10);
				stall_cnt <= stall;
				res_ch.ready <= (stall == 0);
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				if (stall_cnt == 1) res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_req(mode_t m, logic [RW-1:0] u, logic [RW-1:0] n, bit hold);
		request_t r;
		r.is_cfg = 1'b0;
		r.idx = CFG_INIT_OUTER;
		r.data = '0;
		r.mode = m;
		r.ures = u;
		r.nres = n;
		r.hold = hold;
		r.gap = in_calm ? 0 : $urandom_range(10);
		pending.push_back(r);
	endtask

	task automatic push_cfg(cfg_idx_t idx, logic [RW-1:0] v);
		request_t r;
		r.hold = 1'b0;
		r.mode = MODE_OUTER;
		r.ures = '0;
		r.nres = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = v;
		r.gap = $urandom_range(3);
		pending.push_back(r);
	endtask

	task automatic push_settings(logic [15:0] io, logic [DW-1:0] id, logic [DW-1:0] md,
			logic [DW-1:0] mr, logic [4:0] rs, logic [RW-1:0] tg, logic [15:0] mo);
		push_cfg(CFG_INIT_OUTER, RW'(io));
		push_cfg(CFG_INIT_DAMP, RW'(id));
		push_cfg(CFG_MIN_DAMP, RW'(md));
		push_cfg(CFG_MAX_REC, RW'(mr));
		push_cfg(CFG_RAISE_STEPS, RW'(rs));
		push_cfg(CFG_RES_TARGET, tg);
		push_cfg(CFG_MAX_OUTER, RW'(mo));
	endtask

	// one outer iteration of a solver run with a random number of inner tries
	task automatic push_solve(ref int cnt);
		logic [RW-1:0] base, t, nr;
		int            tries;
		base = rand_res() >> $urandom_range(47);
		nr = $urandom_range(3) == 0 ? (rand_res() >> 30) : rand_res() >> $urandom_range(47);
		push_req(MODE_OUTER, rand_res(), rand_res(), 1'b0);
		push_req(MODE_INIT, base, nr, 1'b0);
		cnt += 2;
		tries = $urandom_range(8);
		for (int k = 0; k < tries; k++) begin
			if ($urandom_range(5) == 0)
				t = base - (rand_res() >> $urandom_range(47));
			else
				t = base + (rand_res() >> $urandom_range(20, 47));
			push_req(MODE_TRIAL, t, rand_res(), 1'b0);
			push_req(MODE_INNER, rand_res(), rand_res(), 1'b0);
			cnt += 2;
		end
	endtask

	task automatic push_noise(ref int cnt);
		logic [RW-1:0] u, n;
		u = rand_res();
		n = rand_res();
		case ($urandom_range(3))
			0: u = RES_ONES;
			1: n = '0;
			default: ;
		endcase
		push_req(mode_t'($urandom_range(3)), u, n, 1'b0);
		cnt++;
	endtask

	initial begin
		int n_items, goal;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_OUTER;
		item_ch.user_residual = '0;
		item_ch.normalized_residual_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_INIT_OUTER;
		cfg_ch.data = '0;
		res_ch.ready = 1'b1;
		c_init_outer = 16'd0;
		c_init_damp = 32'd1073741824;
		c_min_damp = 32'd1048576;
		c_max_rec = 32'd1073741824;
		c_raise = 5'd0;
		c_target = RW'(RES_TARGET_INIT);
		c_max_outer = 16'(MAX_OUTER_INIT);
		s_outer = RES_ONES;
		s_trial = RES_ONES;
		s_prev_trial = RES_ONES;
		s_norm = RES_ONES;
		s_damp = DAMP_TWO;
		s_prev_damp = DAMP_TWO;
		s_outer_cnt = 0;
		s_inner_cnt = 0;
		s_rec_cnt = 0;
		s_init = 1'b0;
		s_rec = 1'b0;
		n_items = 0;

		// directed: reset settings, extreme fields, every event kind
		push_req(MODE_OUTER, '0, '0, 1'b0);
		push_req(MODE_INIT, RES_ONES, RES_ONES, 1'b0);
		push_req(MODE_INIT, '0, '0, 1'b0);
		push_req(MODE_OUTER, RES_ONES, RES_ONES, 1'b0);
		push_req(MODE_INIT, 48'h10_0000_0000, 48'h0, 1'b0);
		push_req(MODE_TRIAL, RES_ONES, '0, 1'b0);
		push_req(MODE_INNER, '0, '0, 1'b0);
		push_req(MODE_TRIAL, RES_ONES, '0, 1'b0);
		push_req(MODE_INNER, '0, '0, 1'b0);
		push_req(MODE_OUTER, '0, '0, 1'b0);
		push_req(MODE_INIT, 48'h1_0000_0000, 48'hFFFF, 1'b0);
		push_req(MODE_TRIAL, 48'h1_8000_0000, '0, 1'b0);
		push_req(MODE_INNER, '0, '0, 1'b0);
		push_req(MODE_TRIAL, 48'h1_2000_0000, '0, 1'b0);
		push_req(MODE_INNER, '0, '0, 1'b0);
		push_req(MODE_TRIAL, 48'h1_1000_0000, '0, 1'b0);
		push_req(MODE_INNER, '0, '0, 1'b0);
		push_req(MODE_TRIAL, 48'h1_1000_0000, '0, 1'b0);
		push_req(MODE_INNER, '0, '0, 1'b0);
		push_req(MODE_TRIAL, 48'h0_0000_0001, '0, 1'b0);
		push_req(MODE_INNER, '0, '0, 1'b1);
		n_items = 21;

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: push_settings(16'd0, 32'd0, 32'd0, 32'd0, 5'd0, '0, 16'd0);
				1: push_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31,
					RES_ONES, 16'd65534);
				2: push_settings(16'd0, 32'h4000_0000, 32'h0800_0000, 32'h4000_0000, 5'd3,
					48'd16777, 16'd6);
				3: push_settings(16'd2, 32'h2000_0000, 32'h2000_0000, 32'hFFFF_FFFF, 5'd31,
					48'h1_0000_0000, 16'd3);
				4: push_settings(16'd0, $urandom(), 32'h0010_0000, $urandom(), 5'd5,
					rand_res() >> 16, 16'd20);
				default: push_settings(16'($urandom_range(2)), $urandom(),
					$urandom() >> $urandom_range(31), $urandom(), 5'($urandom_range(31)),
					rand_res() >> $urandom_range(47), 16'($urandom_range(40)));
			endcase
			in_calm = (ph % 3 == 1);
			out_calm = (ph % 4 == 2);
			goal = n_items + 215;
			while (n_items < goal) begin
				if ($urandom_range(4) == 0)
					push_noise(n_items);
				else
					push_solve(n_items);
			end
			push_req(MODE_OUTER, rand_res(), rand_res(), 1'b1);
			n_items++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending.size() == 0);
		@(posedge clk);
		while (item_ch.valid || sent_cnt != got_cnt) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#40ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
